// File: rtl/core/gapbc_pkg.sv
// Shared types, constants and reset values for the gas alarm popup and beep controller.
// Used by every module of the block; depends on nothing else.

package gapbc_pkg;

    localparam int unsigned BEEP_COUNT_DEF = 3;

    localparam int unsigned PPM_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned VIEW_W     = 3;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [VIEW_W-1:0] VIEW_CLOCK = 3'd0;
    localparam logic [VIEW_W-1:0] VIEW_GAS   = 3'd2;

    localparam logic REQ_SHOW_GAS = 1'b0;
    localparam logic REQ_RESTORE  = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HIGH_THR   = 3'd0,
        CFG_LOW_THR    = 3'd1,
        CFG_BEEP_ON    = 3'd2,
        CFG_BEEP_OFF   = 3'd3,
        CFG_POPUP      = 3'd4,
        CFG_INTERVAL   = 3'd5,
        CFG_START_HOUR = 3'd6,
        CFG_END_HOUR   = 3'd7
    } t_cfg_addr;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2
    } t_beep_phase;

    typedef struct packed {
        logic [PPM_W-1:0]  high_thr;
        logic [PPM_W-1:0]  low_thr;
        logic [TIME_W-1:0] beep_on_ms;
        logic [TIME_W-1:0] beep_off_ms;
        logic [TIME_W-1:0] popup_ms;
        logic [TIME_W-1:0] interval_ms;
        logic [HOUR_W-1:0] start_hour;
        logic [HOUR_W-1:0] end_hour;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        high_thr:    16'd1500,
        low_thr:     16'd1200,
        beep_on_ms:  32'd200,
        beep_off_ms: 32'd200,
        popup_ms:    32'd5000,
        interval_ms: 32'd60000,
        start_hour:  5'd8,
        end_hour:    5'd22
    };

    typedef struct packed {
        logic [PPM_W-1:0]  gas_ppm;
        logic [TIME_W-1:0] now_ms;
        logic [HOUR_W-1:0] hour_of_day;
        logic              hour_known;
        logic [VIEW_W-1:0] view_now;
    } t_item;

    typedef struct packed {
        logic              armed;
        logic              popup_on;
        logic              beep_gated;
        logic              beeper_level;
        logic [VIEW_W-1:0] saved_view;
        logic [TIME_W-1:0] popup_end_time;
        logic [TIME_W-1:0] next_popup_time;
        t_beep_phase       beep_phase;
        logic [TIME_W-1:0] phase_start_time;
    } t_state;

    localparam t_state STATE_RESET = '{
        armed:            1'b0,
        popup_on:         1'b0,
        beep_gated:       1'b0,
        beeper_level:     1'b0,
        saved_view:       VIEW_CLOCK,
        popup_end_time:   32'd0,
        next_popup_time:  32'd0,
        beep_phase:       PH_IDLE,
        phase_start_time: 32'd0
    };

    typedef struct packed {
        logic              beeper_on;
        logic              alarm_armed;
        logic              popup_active;
        logic              view_req_valid;
        logic              view_req_kind;
        logic [VIEW_W-1:0] view_req_code;
    } t_result;

endpackage

// File: rtl/core/gapbc_cfg.sv
// Configuration register file: thresholds, beep and popup timings, beeping hours.
// Depends on gapbc_pkg.

module gapbc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gapbc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [gapbc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output gapbc_pkg::t_cfg                     o_cfg
);

    gapbc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= gapbc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (gapbc_pkg::t_cfg_addr'(i_cfg_addr))
                gapbc_pkg::CFG_HIGH_THR: begin
                    r_cfg.high_thr <= i_cfg_wdata[gapbc_pkg::PPM_W-1:0];
                end
                gapbc_pkg::CFG_LOW_THR: begin
                    r_cfg.low_thr <= i_cfg_wdata[gapbc_pkg::PPM_W-1:0];
                end
                gapbc_pkg::CFG_BEEP_ON: begin
                    r_cfg.beep_on_ms <= i_cfg_wdata;
                end
                gapbc_pkg::CFG_BEEP_OFF: begin
                    r_cfg.beep_off_ms <= i_cfg_wdata;
                end
                gapbc_pkg::CFG_POPUP: begin
                    r_cfg.popup_ms <= i_cfg_wdata;
                end
                gapbc_pkg::CFG_INTERVAL: begin
                    r_cfg.interval_ms <= i_cfg_wdata;
                end
                gapbc_pkg::CFG_START_HOUR: begin
                    r_cfg.start_hour <= i_cfg_wdata[gapbc_pkg::HOUR_W-1:0];
                end
                gapbc_pkg::CFG_END_HOUR: begin
                    r_cfg.end_hour <= i_cfg_wdata[gapbc_pkg::HOUR_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/gapbc_step.sv
// Next-state and result logic for one tick: alarm hysteresis, popup open/close,
// beep sequencing and the view request. Purely combinational; depends on gapbc_pkg.

module gapbc_step #(
    parameter int unsigned BEEP_COUNT = gapbc_pkg::BEEP_COUNT_DEF
) (
    input  gapbc_pkg::t_cfg                         i_cfg,
    input  gapbc_pkg::t_state                       i_state,
    input  logic [$clog2(BEEP_COUNT+1)-1:0]         i_beeps,
    input  gapbc_pkg::t_item                        i_item,
    output gapbc_pkg::t_state                       o_state,
    output logic [$clog2(BEEP_COUNT+1)-1:0]         o_beeps,
    output gapbc_pkg::t_result                      o_result
);

    localparam int unsigned BEEPS_W = $clog2(BEEP_COUNT + 1);

    gapbc_pkg::t_state                 s;
    logic [BEEPS_W-1:0]                beeps;
    logic                              req;
    logic                              kind;
    logic [gapbc_pkg::VIEW_W-1:0]      code;
    logic                              opened;
    logic                              allow;
    logic                              should_close;
    logic [gapbc_pkg::TIME_W-1:0]      elapsed;

    always_comb begin
        s            = i_state;
        beeps        = i_beeps;
        req          = 1'b0;
        kind         = gapbc_pkg::REQ_SHOW_GAS;
        code         = gapbc_pkg::VIEW_CLOCK;
        opened       = 1'b0;
        allow        = 1'b1;
        should_close = 1'b0;

        // The arm test takes priority, so reversed thresholds still arm first.
        if (i_item.gas_ppm >= i_cfg.high_thr && !s.armed) begin
            s.armed           = 1'b1;
            s.next_popup_time = i_item.now_ms;
        end else if (i_item.gas_ppm < i_cfg.low_thr && s.armed) begin
            s.armed = 1'b0;
            if (s.popup_on) begin
                s.popup_on = 1'b0;
                if (i_item.view_now == gapbc_pkg::VIEW_GAS) begin
                    req  = 1'b1;
                    kind = gapbc_pkg::REQ_RESTORE;
                    code = s.saved_view;
                end
                if (s.beep_phase != gapbc_pkg::PH_IDLE) begin
                    s.beeper_level = 1'b0;
                    s.beep_phase   = gapbc_pkg::PH_IDLE;
                end
            end
        end

        if (s.armed && !s.popup_on && i_item.now_ms >= s.next_popup_time) begin
            s.popup_on   = 1'b1;
            opened       = 1'b1;
            s.saved_view = i_item.view_now;
            req          = 1'b1;
            kind         = gapbc_pkg::REQ_SHOW_GAS;
            code         = gapbc_pkg::VIEW_GAS;
            if (i_item.hour_known && (i_item.hour_of_day < i_cfg.start_hour ||
                                      i_item.hour_of_day >= i_cfg.end_hour)) begin
                allow = 1'b0;
            end
            if (allow) begin
                s.beeper_level     = 1'b1;
                s.beep_phase       = gapbc_pkg::PH_ON;
                beeps              = '0;
                s.phase_start_time = i_item.now_ms;
                s.beep_gated       = 1'b1;
            end else begin
                s.beep_phase     = gapbc_pkg::PH_IDLE;
                s.beep_gated     = 1'b0;
                s.popup_end_time = i_item.now_ms + i_cfg.popup_ms;
            end
        end

        // Durations are differences modulo 2^32.
        elapsed = i_item.now_ms - s.phase_start_time;
        if (s.beep_phase == gapbc_pkg::PH_ON && elapsed >= i_cfg.beep_on_ms) begin
            s.beeper_level = 1'b0;
            beeps          = beeps + BEEPS_W'(1);
            if (beeps >= BEEPS_W'(BEEP_COUNT)) begin
                s.beep_phase = gapbc_pkg::PH_IDLE;
            end else begin
                s.beep_phase       = gapbc_pkg::PH_OFF;
                s.phase_start_time = i_item.now_ms;
            end
        end else if (s.beep_phase == gapbc_pkg::PH_OFF && elapsed >= i_cfg.beep_off_ms) begin
            s.beeper_level     = 1'b1;
            s.beep_phase       = gapbc_pkg::PH_ON;
            s.phase_start_time = i_item.now_ms;
        end

        should_close = s.beep_gated ? (s.beep_phase == gapbc_pkg::PH_IDLE)
                                    : (i_item.now_ms >= s.popup_end_time);
        if (s.popup_on && should_close) begin
            // A popup that opened on this same tick counts as showing the gas view.
            if (opened || i_item.view_now == gapbc_pkg::VIEW_GAS) begin
                req  = 1'b1;
                kind = gapbc_pkg::REQ_RESTORE;
                code = s.saved_view;
            end else begin
                req  = 1'b0;
                kind = gapbc_pkg::REQ_SHOW_GAS;
                code = gapbc_pkg::VIEW_CLOCK;
            end
            s.popup_on        = 1'b0;
            s.next_popup_time = i_item.now_ms + i_cfg.interval_ms;
        end
    end

    assign o_state                 = s;
    assign o_beeps                 = beeps;
    assign o_result.beeper_on      = s.beeper_level;
    assign o_result.alarm_armed    = s.armed;
    assign o_result.popup_active   = s.popup_on;
    assign o_result.view_req_valid = req;
    assign o_result.view_req_kind  = req ? kind : gapbc_pkg::REQ_SHOW_GAS;
    assign o_result.view_req_code  = req ? code : gapbc_pkg::VIEW_CLOCK;

endmodule

// File: rtl/core/gas_alarm_popup_beep_controller.sv
// Channel   | dir | fields (lowest bit first)
// s_axis    | in  | tdata: gas_ppm[15:0] now_ms[47:16] hour_of_day[52:48] view_now[55:53];
//           |     | tuser: hour_known
// m_axis    | out | tdata: beeper_on alarm_armed popup_active view_req_valid
//           |     |        view_req_code[6:4], bit 7 zero; tuser: view_req_kind
// i_cfg_*   | in  | write enable, register index, 32-bit write data
//
// One tick transaction is taken every cycle unless a stalled result holds the input
// register full. A transaction lands in the input register; once the result register
// is free, the tick logic updates the controller state and loads the result register.
// The state update for one tick is a single pass of compares and 32-bit adds.
// A stalled result holds in the result register while the input register still
// takes one more transaction. Reset (synchronous, active low) restores the state
// and register defaults.
//
// Top level of the gas alarm popup and beep controller.
// Depends on gapbc_pkg, gapbc_cfg and gapbc_step.

module gas_alarm_popup_beep_controller #(
    parameter int unsigned BEEP_COUNT = gapbc_pkg::BEEP_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gapbc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [gapbc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // gas_ppm, now_ms, hour_of_day, view_now
    input  logic [gapbc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // hour_known
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // beeper_on, alarm_armed, popup_active, view_req_valid, view_req_code, zero pad
    output logic [gapbc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // view_req_kind
    output logic                                m_axis_tuser
);

    localparam int unsigned BEEPS_W = $clog2(BEEP_COUNT + 1);

    gapbc_pkg::t_cfg    cfg;
    gapbc_pkg::t_item   n_in;
    gapbc_pkg::t_item   r_in;
    logic               r_in_valid;
    gapbc_pkg::t_state  r_state;
    gapbc_pkg::t_state  n_state;
    logic [BEEPS_W-1:0] r_beeps;
    logic [BEEPS_W-1:0] n_beeps;
    gapbc_pkg::t_result n_out;
    gapbc_pkg::t_result r_out;
    logic               r_out_valid;
    logic               in_fire;
    logic               proc_fire;

    gapbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    gapbc_step #(
        .BEEP_COUNT (BEEP_COUNT)
    ) u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_beeps  (r_beeps),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_beeps  (n_beeps),
        .o_result (n_out)
    );

    assign n_in.gas_ppm     = s_axis_tdata[15:0];
    assign n_in.now_ms      = s_axis_tdata[47:16];
    assign n_in.hour_of_day = s_axis_tdata[52:48];
    assign n_in.view_now    = s_axis_tdata[55:53];
    assign n_in.hour_known  = s_axis_tuser;

    assign proc_fire     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= gapbc_pkg::STATE_RESET;
            r_beeps     <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end
            if (proc_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_beeps     <= n_beeps;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= n_in;
        end
        if (proc_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.view_req_code, r_out.view_req_valid,
                            r_out.popup_active, r_out.alarm_armed, r_out.beeper_on};
    assign m_axis_tuser  = r_out.view_req_kind;

endmodule

// File: rtl/core/gapbc_checker.sv
// Port-level checks for the gas alarm popup and beep controller, bound to the top level.
// Depends on gapbc_pkg and gas_alarm_popup_beep_controller.

module gapbc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [gapbc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser
);

    // A stalled result must stay offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Without a request, kind and code read as zero.
    a_no_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[3] |->
            m_axis_tdata[6:4] == gapbc_pkg::VIEW_CLOCK &&
            m_axis_tuser == gapbc_pkg::REQ_SHOW_GAS)
        else $error("request fields set without a request");

    // A show request always names the gas view.
    a_show_is_gas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] && m_axis_tuser == gapbc_pkg::REQ_SHOW_GAS |->
            m_axis_tdata[6:4] == gapbc_pkg::VIEW_GAS)
        else $error("show request with a view other than gas");

    // The beeper only sounds under an open popup, and a popup only stays open while armed.
    a_beep_popup_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[2]) &&
                          (!m_axis_tdata[2] || m_axis_tdata[1]))
        else $error("beeper or popup active outside its alarm state");

endmodule

bind gas_alarm_popup_beep_controller gapbc_checker u_gapbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: bench/tb.sv
// Self-checking bench for the gas alarm popup and beep controller: directed ticks, then
// randomized gas episodes under several register settings, with random stalls on both streams.
// Depends on gapbc_pkg and gas_alarm_popup_beep_controller.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TONES_PER_POPUP = gapbc_pkg::BEEP_COUNT_DEF;
    localparam int unsigned LIMIT_CYCLES    = 200_000;

    typedef enum {GAS_ABOVE, GAS_BELOW, GAS_BETWEEN, GAS_ANY} t_gas_trend;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [gapbc_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [gapbc_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    // gas_ppm, now_ms, hour_of_day, view_now
    logic [gapbc_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    // hour_known
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // beeper_on, alarm_armed, popup_active, view_req_valid, view_req_code, zero pad
    logic [gapbc_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    // view_req_kind
    logic                             m_axis_tuser;

    gas_alarm_popup_beep_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predicted controller state and register copy.
    gapbc_pkg::t_cfg                  settings;
    logic                             alarm_on;
    logic                             popup_shown;
    logic                             beeps_timed;
    logic                             tone_level;
    logic [gapbc_pkg::VIEW_W-1:0]     view_saved;
    logic [gapbc_pkg::TIME_W-1:0]     popup_deadline;
    logic [gapbc_pkg::TIME_W-1:0]     next_popup_at;
    gapbc_pkg::t_beep_phase           tone_phase;
    logic [3:0]                       tones_done;
    logic [gapbc_pkg::TIME_W-1:0]     tone_start;

    gapbc_pkg::t_result               awaited_status[$];
    int unsigned                      mismatches;
    int unsigned                      cycle_count;

    // Stimulus shaping.
    logic                             src_idle;
    logic                             sink_idle;
    int                               sink_hold_cycles;
    logic [gapbc_pkg::TIME_W-1:0]     clock_ms;
    logic [gapbc_pkg::VIEW_W-1:0]     screen_view;
    int                               step_max;
    int                               episode_left;
    t_gas_trend                       episode_trend;
    logic [gapbc_pkg::HOUR_W-1:0]     episode_hour;
    logic                             episode_hour_known;

    function automatic void reset_alarm_model();
        settings       = gapbc_pkg::CFG_RESET;
        alarm_on       = 1'b0;
        popup_shown    = 1'b0;
        beeps_timed    = 1'b0;
        tone_level     = 1'b0;
        view_saved     = gapbc_pkg::VIEW_CLOCK;
        popup_deadline = '0;
        next_popup_at  = '0;
        tone_phase     = gapbc_pkg::PH_IDLE;
        tones_done     = '0;
        tone_start     = '0;
    endfunction

    function automatic gapbc_pkg::t_result advance_alarm(gapbc_pkg::t_item it);
        gapbc_pkg::t_result           r;
        logic                         req;
        logic                         kind;
        logic [gapbc_pkg::VIEW_W-1:0] code;
        logic                         opened;
        logic                         allow;
        logic                         closing;
        logic [gapbc_pkg::TIME_W-1:0] elapsed;
        req    = 1'b0;
        kind   = gapbc_pkg::REQ_SHOW_GAS;
        code   = gapbc_pkg::VIEW_CLOCK;
        opened = 1'b0;

        // The arm test wins when the thresholds are reversed.
        if (it.gas_ppm >= settings.high_thr && !alarm_on) begin
            alarm_on      = 1'b1;
            next_popup_at = it.now_ms;
        end else if (it.gas_ppm < settings.low_thr && alarm_on) begin
            alarm_on = 1'b0;
            if (popup_shown) begin
                popup_shown = 1'b0;
                if (it.view_now == gapbc_pkg::VIEW_GAS) begin
                    req  = 1'b1;
                    kind = gapbc_pkg::REQ_RESTORE;
                    code = view_saved;
                end
                if (tone_phase != gapbc_pkg::PH_IDLE) begin
                    tone_level = 1'b0;
                    tone_phase = gapbc_pkg::PH_IDLE;
                end
            end
        end

        if (alarm_on && !popup_shown && it.now_ms >= next_popup_at) begin
            popup_shown = 1'b1;
            opened      = 1'b1;
            view_saved  = it.view_now;
            req         = 1'b1;
            kind        = gapbc_pkg::REQ_SHOW_GAS;
            code        = gapbc_pkg::VIEW_GAS;
            allow = !(it.hour_known && (it.hour_of_day < settings.start_hour ||
                                        it.hour_of_day >= settings.end_hour));
            if (allow) begin
                tone_level  = 1'b1;
                tone_phase  = gapbc_pkg::PH_ON;
                tones_done  = '0;
                tone_start  = it.now_ms;
                beeps_timed = 1'b1;
            end else begin
                tone_phase     = gapbc_pkg::PH_IDLE;
                beeps_timed    = 1'b0;
                popup_deadline = it.now_ms + settings.popup_ms;
            end
        end

        elapsed = it.now_ms - tone_start;
        if (tone_phase == gapbc_pkg::PH_ON && elapsed >= settings.beep_on_ms) begin
            tone_level = 1'b0;
            tones_done = tones_done + 4'd1;
            if (tones_done >= 4'(TONES_PER_POPUP)) begin
                tone_phase = gapbc_pkg::PH_IDLE;
            end else begin
                tone_phase = gapbc_pkg::PH_OFF;
                tone_start = it.now_ms;
            end
        end else if (tone_phase == gapbc_pkg::PH_OFF && elapsed >= settings.beep_off_ms) begin
            tone_level = 1'b1;
            tone_phase = gapbc_pkg::PH_ON;
            tone_start = it.now_ms;
        end

        closing = beeps_timed ? (tone_phase == gapbc_pkg::PH_IDLE)
                              : (it.now_ms >= popup_deadline);
        if (popup_shown && closing) begin
            // A popup that opened on this very tick counts as showing the gas view.
            if (opened || it.view_now == gapbc_pkg::VIEW_GAS) begin
                req  = 1'b1;
                kind = gapbc_pkg::REQ_RESTORE;
                code = view_saved;
            end else begin
                req  = 1'b0;
                kind = gapbc_pkg::REQ_SHOW_GAS;
                code = gapbc_pkg::VIEW_CLOCK;
            end
            popup_shown   = 1'b0;
            next_popup_at = it.now_ms + settings.interval_ms;
        end

        r.beeper_on      = tone_level;
        r.alarm_armed    = alarm_on;
        r.popup_active   = popup_shown;
        r.view_req_valid = req;
        r.view_req_kind  = req ? kind : gapbc_pkg::REQ_SHOW_GAS;
        r.view_req_code  = req ? code : gapbc_pkg::VIEW_CLOCK;
        return r;
    endfunction

    function automatic gapbc_pkg::t_item make_tick(int unsigned ppm,
                                                   logic [gapbc_pkg::TIME_W-1:0] now,
                                                   int unsigned hour, logic known,
                                                   int unsigned view);
        gapbc_pkg::t_item it;
        it.gas_ppm     = ppm[gapbc_pkg::PPM_W-1:0];
        it.now_ms      = now;
        it.hour_of_day = hour[gapbc_pkg::HOUR_W-1:0];
        it.hour_known  = known;
        it.view_now    = view[gapbc_pkg::VIEW_W-1:0];
        return it;
    endfunction

    // Random ticks come in episodes: a gas trend, an hour, and time moving forward,
    // with a follower that mostly shows whatever view the block last asked for.
    function automatic gapbc_pkg::t_item next_random_tick();
        int unsigned hi;
        int unsigned lo;
        int unsigned ppm;
        int unsigned pick;
        t_gas_trend  trend;
        hi = settings.high_thr;
        lo = settings.low_thr;
        if (episode_left == 0) begin
            episode_left = $urandom_range(5, 40);
            pick = $urandom_range(0, 99);
            episode_trend = (pick < 35) ? GAS_ABOVE : (pick < 65) ? GAS_BELOW :
                            (pick < 90) ? GAS_BETWEEN : GAS_ANY;
            episode_hour_known = ($urandom_range(0, 3) != 0);
            episode_hour = ($urandom_range(0, 99) < 12)
                           ? gapbc_pkg::HOUR_W'($urandom_range(24, 31))
                           : gapbc_pkg::HOUR_W'($urandom_range(0, 23));
        end
        episode_left--;
        trend = ($urandom_range(0, 9) == 0) ? GAS_ANY : episode_trend;
        case (trend)
            GAS_ABOVE:   ppm = $urandom_range(hi, (hi > 65235) ? 65535 : hi + 300);
            GAS_BELOW:   ppm = (lo == 0) ? 0 : $urandom_range((lo > 300) ? lo - 300 : 0, lo - 1);
            GAS_BETWEEN: ppm = $urandom_range(lo, hi);
            default:     ppm = $urandom_range(0, 65535);
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            clock_ms = $urandom;
        end else if (pick < 6) begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        end else begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
        end

        if ($urandom_range(0, 99) < 5) begin
            episode_hour = gapbc_pkg::HOUR_W'($urandom_range(0, 31));
        end
        return make_tick(ppm, clock_ms, episode_hour, episode_hour_known,
                         ($urandom_range(0, 99) < 85) ? screen_view : $urandom_range(0, 7));
    endfunction

    task automatic send_tick(input gapbc_pkg::t_item it);
        gapbc_pkg::t_result r;
        int                 gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.view_now, it.hour_of_day, it.now_ms, it.gas_ppm};
        s_axis_tuser  <= it.hour_known;
        r = advance_alarm(it);
        awaited_status.push_back(r);
        if (r.view_req_valid) begin
            screen_view = (r.view_req_kind == gapbc_pkg::REQ_RESTORE) ? r.view_req_code
                                                                     : gapbc_pkg::VIEW_GAS;
        end
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Wait until every outstanding result is back; the block is then idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input gapbc_pkg::t_cfg_addr addr,
                                  input logic [gapbc_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (addr)
            gapbc_pkg::CFG_HIGH_THR:   settings.high_thr    = value[gapbc_pkg::PPM_W-1:0];
            gapbc_pkg::CFG_LOW_THR:    settings.low_thr     = value[gapbc_pkg::PPM_W-1:0];
            gapbc_pkg::CFG_BEEP_ON:    settings.beep_on_ms  = value;
            gapbc_pkg::CFG_BEEP_OFF:   settings.beep_off_ms = value;
            gapbc_pkg::CFG_POPUP:      settings.popup_ms    = value;
            gapbc_pkg::CFG_INTERVAL:   settings.interval_ms = value;
            gapbc_pkg::CFG_START_HOUR: settings.start_hour  = value[gapbc_pkg::HOUR_W-1:0];
            gapbc_pkg::CFG_END_HOUR:   settings.end_hour    = value[gapbc_pkg::HOUR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input gapbc_pkg::t_cfg c);
        settle();
        write_register(gapbc_pkg::CFG_HIGH_THR, gapbc_pkg::CFG_DATA_W'(c.high_thr));
        write_register(gapbc_pkg::CFG_LOW_THR, gapbc_pkg::CFG_DATA_W'(c.low_thr));
        write_register(gapbc_pkg::CFG_BEEP_ON, c.beep_on_ms);
        write_register(gapbc_pkg::CFG_BEEP_OFF, c.beep_off_ms);
        write_register(gapbc_pkg::CFG_POPUP, c.popup_ms);
        write_register(gapbc_pkg::CFG_INTERVAL, c.interval_ms);
        write_register(gapbc_pkg::CFG_START_HOUR, gapbc_pkg::CFG_DATA_W'(c.start_hour));
        write_register(gapbc_pkg::CFG_END_HOUR, gapbc_pkg::CFG_DATA_W'(c.end_hour));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input gapbc_pkg::t_cfg c, input int step, input int count);
        apply_settings(c);
        step_max     = step;
        episode_left = 0;
        src_idle     = ($urandom_range(0, 3) != 0);
        sink_idle    = ($urandom_range(0, 3) != 0);
        repeat (count) send_tick(next_random_tick());
    endtask

    task automatic test_directed_ticks();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_tick(make_tick(0, 32'd0, 0, 1'b0, 0));
        // Full-scale reading at the top of the clock with odd hour and view: the popup
        // deadline wraps, so it opens and closes at once and restores view 7.
        send_tick(make_tick(65535, 32'hFFFF_FFFF, 31, 1'b1, 7));
        send_tick(make_tick(1300, 32'd1000, 10, 1'b1, 1));
        // A full beep popup inside the allowed hours.
        send_tick(make_tick(1300, 32'd60000, 10, 1'b1, 1));
        send_tick(make_tick(1300, 32'd60100, 10, 1'b1, 2));
        send_tick(make_tick(1300, 32'd60200, 10, 1'b1, 2));
        send_tick(make_tick(1300, 32'd60400, 10, 1'b1, 2));
        send_tick(make_tick(1300, 32'd60600, 10, 1'b1, 2));
        send_tick(make_tick(1300, 32'd60800, 10, 1'b1, 2));
        send_tick(make_tick(1300, 32'd61000, 10, 1'b1, 2));
        send_tick(make_tick(1199, 32'd61100, 10, 1'b1, 1));
        // Unknown hour beeps; disarming mid-beep restores and silences.
        send_tick(make_tick(1500, 32'd61200, 3, 1'b0, 3));
        send_tick(make_tick(1000, 32'd61250, 3, 1'b0, 2));
        // Outside the hours the popup times out; closing off the gas view asks nothing.
        send_tick(make_tick(1500, 32'd70000, 5, 1'b1, 4));
        send_tick(make_tick(1300, 32'd75000, 5, 1'b1, 0));
        send_tick(make_tick(65535, 32'd200000, 22, 1'b1, 2));
        send_tick(make_tick(0, 32'd200001, 22, 1'b1, 5));
        send_tick(make_tick(2000, 32'd300000, 8, 1'b1, 6));
        send_tick(make_tick(0, 32'd300001, 8, 1'b1, 2));
        send_tick(make_tick(1500, 32'd400000, 21, 1'b1, 0));
        send_tick(make_tick(1499, 32'd400200, 21, 1'b1, 2));
    endtask

    task automatic test_hysteresis_and_beeps();
        clock_ms    = $urandom;
        screen_view = gapbc_pkg::VIEW_CLOCK;
        // Fields: high, low, beep on, beep off, popup, interval, start hour, end hour.
        run_phase('{16'd1500, 16'd1200, 32'd20, 32'd20, 32'd100, 32'd200, 5'd8, 5'd22}, 15, 100);
        run_phase('{16'd65535, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 5'd0, 5'd24}, 50, 100);
        run_phase('{16'd800, 16'd600, 32'd1, 32'd0, 32'd1, 32'd0, 5'd0, 5'd24}, 3, 100);
        run_phase('{16'd1000, 16'd2000, 32'd10, 32'd5, 32'd40, 32'd30, 5'd24, 5'd0}, 8, 100);
        run_phase('{16'd0, 16'd65535, 32'd5, 32'd5, 32'd20, 32'd10, 5'd12, 5'd12}, 4, 100);
    endtask

    // The receiver holds off long enough that both pipeline registers fill and the
    // input stream backs up while the sender keeps offering.
    task automatic test_output_backpressure();
        apply_settings('{16'd1500, 16'd1200, 32'd15, 32'd10, 32'd60, 32'd80, 5'd6, 5'd20});
        step_max         = 10;
        src_idle         = 1'b0;
        sink_idle        = 1'b1;
        sink_hold_cycles = 300;
        repeat (60) send_tick(next_random_tick());
    endtask

    task automatic test_random_settings();
        gapbc_pkg::t_cfg c;
        repeat (3) begin
            c.high_thr    = $urandom_range(0, 65535);
            c.low_thr     = $urandom_range(0, 65535);
            c.beep_on_ms  = $urandom_range(1, 40);
            c.beep_off_ms = $urandom_range(0, 40);
            c.popup_ms    = $urandom_range(1, 150);
            c.interval_ms = $urandom_range(0, 300);
            c.start_hour  = $urandom_range(0, 24);
            c.end_hour    = $urandom_range(0, 24);
            run_phase(c, $urandom_range(1, 20), 80);
        end
    endtask

    function automatic void check_field(string what, logic [3:0] want, logic [3:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        gapbc_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_status.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %h/%b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = awaited_status.pop_front();
                check_field("beeper_on", 4'(want.beeper_on), 4'(m_axis_tdata[0]));
                check_field("alarm_armed", 4'(want.alarm_armed), 4'(m_axis_tdata[1]));
                check_field("popup_active", 4'(want.popup_active), 4'(m_axis_tdata[2]));
                check_field("view_req_valid", 4'(want.view_req_valid), 4'(m_axis_tdata[3]));
                check_field("view_req_code", 4'(want.view_req_code), 4'(m_axis_tdata[6:4]));
                check_field("tdata pad", 4'd0, 4'(m_axis_tdata[7]));
                check_field("view_req_kind", 4'(want.view_req_kind), 4'(m_axis_tuser));
            end
        end
    end

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = sink_idle ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        mismatches       = 0;
        cycle_count      = 0;
        sink_hold_cycles = 0;
        src_idle         = 1'b1;
        sink_idle        = 1'b1;
        step_max         = 10;
        episode_left     = 0;
        clock_ms         = '0;
        screen_view      = gapbc_pkg::VIEW_CLOCK;
        reset_alarm_model();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= gapbc_pkg::CFG_HIGH_THR;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ticks();
        test_hysteresis_and_beeps();
        test_output_backpressure();
        test_random_settings();

        settle();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0 && awaited_status.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/gapbc_pkg.sv
rtl/core/gapbc_cfg.sv
rtl/core/gapbc_step.sv
rtl/core/gas_alarm_popup_beep_controller.sv
rtl/core/gapbc_checker.sv
bench/tb.sv
